### hdl/tea_pkg.sv
package tea_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned RoundCount = 32;
  localparam int unsigned NumStages  = 2 * RoundCount;
  localparam int unsigned KeyWords   = 4;
  localparam int unsigned KeyIdxW    = $clog2(KeyWords);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] TeaDelta = 32'h9e37_79b9;
  localparam int unsigned      ShiftLeft  = 4;
  localparam int unsigned      ShiftRight = 5;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [KeyWords-1:0] key_t;

  typedef enum logic [KeyIdxW-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } key_idx_e;

  typedef struct packed {
    word_t left;
    word_t right;
  } tea_block_t;

  function automatic word_t tea_mix(word_t h, word_t s, word_t ka, word_t kb);
    return ((h << ShiftLeft) + ka) ^ (h + s) ^ ((h >> ShiftRight) + kb);
  endfunction

endpackage

### hdl/tea_queue.sv
module tea_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tea_pkg::tea_block_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output tea_pkg::tea_block_t data_o,
  output logic                empty_o
);
  import tea_pkg::*;

  tea_block_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] next_ptr(logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### hdl/tea_rounds.sv
module tea_rounds (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  tea_pkg::tea_block_t in_block_i,
  input  tea_pkg::key_t       key_i,
  output logic                out_valid_o,
  output tea_pkg::tea_block_t out_block_o
);
  import tea_pkg::*;

  logic [NumStages-1:0] valid_q;
  tea_block_t           data_q [NumStages];
  tea_block_t           data_d [NumStages];

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    localparam logic [63:0] SumWide   = 64'(TeaDelta) * 64'(g / 2 + 1);
    localparam word_t       StageSum  = SumWide[WordW-1:0];
    tea_block_t src;

    if (g == 0) begin : g_first
      assign src = in_block_i;
    end else begin : g_next
      assign src = data_q[g-1];
    end

    if (g % 2 == 0) begin : g_left
      always_comb begin
        data_d[g].left  = src.left +
                          tea_mix(src.right, StageSum, key_i[KEY_WORD_0], key_i[KEY_WORD_1]);
        data_d[g].right = src.right;
      end
    end else begin : g_right
      always_comb begin
        data_d[g].left  = src.left;
        data_d[g].right = src.right +
                          tea_mix(src.left, StageSum, key_i[KEY_WORD_2], key_i[KEY_WORD_3]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) data_q <= data_d;
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_block_o = data_q[NumStages-1];

endmodule

### hdl/tea_block_encrypt.sv
// TEA encryption of one 64-bit block per request under a 128-bit key held in
// four 32-bit key registers (index 0..3, written through cfg_we_i; the user
// must write them only while idle, which the block itself does not enforce).
// A two-entry input queue feeds a pipeline of 64 half-round stages (two per
// round, 32 rounds), which drains into a two-entry result queue. One block is
// accepted per cycle while the input queue is not full. When the result queue
// fills, the whole round pipeline holds.
module tea_block_encrypt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tea_pkg::KeyIdxW-1:0]  cfg_idx_i,
  input  logic [tea_pkg::WordW-1:0]    cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [tea_pkg::WordW-1:0]    plain_left_i,
  input  logic [tea_pkg::WordW-1:0]    plain_right_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [tea_pkg::WordW-1:0]    cipher_left_o,
  output logic [tea_pkg::WordW-1:0]    cipher_right_o
);
  import tea_pkg::*;

  key_t       key_q;
  tea_block_t in_block, head_block, last_block, res_block;
  logic       inq_empty, outq_full, adv, last_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign in_block = '{left: plain_left_i, right: plain_right_i};
  assign adv      = !outq_full;

  tea_queue u_inq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_block),
    .full_o  (full),
    .pop_i   (adv),
    .data_o  (head_block),
    .empty_o (inq_empty)
  );

  tea_rounds u_rounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (!inq_empty),
    .in_block_i  (head_block),
    .key_i       (key_q),
    .out_valid_o (last_valid),
    .out_block_o (last_block)
  );

  tea_queue u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (last_valid && adv),
    .data_i  (last_block),
    .full_o  (outq_full),
    .pop_i   (pop),
    .data_o  (res_block),
    .empty_o (empty)
  );

  assign cipher_left_o  = res_block.left;
  assign cipher_right_o = res_block.right;

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_valid && !adv) |=> (last_valid && $stable(last_block)))
    else $error("pipeline output lost while result queue full");

  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({cipher_left_o, cipher_right_o}))
    else $error("unknown value on a waiting result");

  a_keep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cipher_left_o) && $stable(cipher_right_o)))
    else $error("waiting result changed or dropped");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outq_full && !pop) |=> outq_full)
    else $error("result queue drained without pop");

endmodule
